FILE: rtl/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // Default geometry of the rasterizer.
  localparam int COORD_BITS_DEF  = 10;
  localparam int RADIUS_BITS_DEF = 9;

  // Fixed width of the pixel coordinates on the result side.
  localparam int OUT_W = 12;

  // Depth of the request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Request kinds carried on the action field.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/mer_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_front #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               action,
  input  wire logic [COORD_BITS-1:0]              center_x,
  input  wire logic [COORD_BITS-1:0]              center_y,
  input  wire logic [RADIUS_BITS-1:0]             radius_x,
  input  wire logic [RADIUS_BITS-1:0]             radius_y,
  output logic                                    push_valid,
  input  wire logic                               push_ready,
  output logic [1+2*COORD_BITS+2*RADIUS_BITS-1:0] push_data
);
  import mer_pkg::*;

  localparam int ENTRY_W = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS;

  logic               hold_valid;
  logic [ENTRY_W-1:0] hold_data;
  logic               kind;

  // A start request carries its geometry; a step request carries none that matters.
  assign kind = (action == ACT_START) ? ACT_START : ACT_STEP;

  // The input register stays open while it is empty or drains this cycle.
  assign in_ready = !hold_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Capture the classified request.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (kind == ACT_START) begin
        hold_data <= {kind, center_x, center_y, radius_x, radius_y};
      end else begin
        hold_data <= {kind, {(ENTRY_W-1){1'b0}}};
      end
    end
  end

  assign push_valid = hold_valid;
  assign push_data  = hold_data;

endmodule

`default_nettype wire

FILE: rtl/mer_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_queue #(
  parameter int DATA_W = 39,
  parameter int DEPTH  = mer_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);
  import mer_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mer_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_back #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    pop_valid,
  output logic                                         pop_ready,
  input  wire logic [1+2*COORD_BITS+2*RADIUS_BITS-1:0] pop_data,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [mer_pkg::OUT_W-1:0]             left_x,
  output logic signed [mer_pkg::OUT_W-1:0]             right_x,
  output logic signed [mer_pkg::OUT_W-1:0]             top_y,
  output logic signed [mer_pkg::OUT_W-1:0]             bottom_y,
  output logic                                         last
);
  import mer_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int R      = RADIUS_BITS;
  localparam int OFF_W  = R + 1;
  localparam int SQ_W   = 2 * R;
  localparam int TERM_W = 3 * R + 3;
  localparam int DEC_W  = 4 * R + 4;
  localparam int TX_W   = OFF_W + 1;
  localparam int PSQ_W  = 2 * R + 4;
  localparam int MA_W   = SQ_W;
  localparam int MB_W   = PSQ_W;
  localparam int MAX_CO = (C > OUT_W) ? C : OUT_W;
  localparam int EXT_W  = ((MAX_CO > OFF_W) ? MAX_CO : OFF_W) + 1;

  // Sequencer states.
  localparam logic [3:0] ST_READY = 4'd0;
  localparam logic [3:0] ST_RX    = 4'd1;
  localparam logic [3:0] ST_RY    = 4'd2;
  localparam logic [3:0] ST_VT    = 4'd3;
  localparam logic [3:0] ST_SD    = 4'd4;
  localparam logic [3:0] ST_W1    = 4'd5;
  localparam logic [3:0] ST_W2    = 4'd6;
  localparam logic [3:0] ST_W3    = 4'd7;
  localparam logic [3:0] ST_W4    = 4'd8;
  localparam logic [3:0] ST_W5    = 4'd9;
  localparam logic [3:0] ST_W6    = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;

  // Control state.
  logic [3:0] state;
  logic       busy;
  logic       in_region_two;

  // Walk state.
  logic [OFF_W-1:0]  offset_x;
  logic [OFF_W-1:0]  offset_y;
  logic [DEC_W-1:0]  decision;
  logic [TERM_W-1:0] horiz_term;
  logic [TERM_W-1:0] vert_term;
  logic [SQ_W-1:0]   rx_squared;
  logic [SQ_W-1:0]   ry_squared;
  logic [C-1:0]      origin_x;
  logic [C-1:0]      origin_y;
  logic [R-1:0]      rad_x;
  logic [R-1:0]      rad_y;
  logic [PSQ_W-1:0]  t_sq;
  logic [PSQ_W-1:0]  y_sq;
  logic [DEC_W-1:0]  prod;

  // Fields of the request at the head of the queue.
  logic         req_kind;
  logic [C-1:0] req_cx;
  logic [C-1:0] req_cy;
  logic [R-1:0] req_rx;
  logic [R-1:0] req_ry;

  assign {req_kind, req_cx, req_cy, req_rx, req_ry} = pop_data;
  assign pop_ready = (state == ST_READY);

  // Shared multiplier operands, selected by the sequencer state.
  logic [TX_W-1:0]  tx;
  logic [OFF_W-1:0] ym1_abs;
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;

  assign tx      = {offset_x, 1'b1};
  // The square of y - 1 is 1 when y is already zero.
  assign ym1_abs = (offset_y == '0) ? OFF_W'(1) : offset_y - 1'b1;

  always_comb begin
    case (state)
      ST_RX: begin
        mul_a = MA_W'(rad_x);
        mul_b = MB_W'(rad_x);
      end
      ST_RY: begin
        mul_a = MA_W'(rad_y);
        mul_b = MB_W'(rad_y);
      end
      ST_VT: begin
        mul_a = rx_squared;
        mul_b = MB_W'(rad_y);
      end
      ST_W1: begin
        mul_a = MA_W'(tx);
        mul_b = MB_W'(tx);
      end
      ST_W2: begin
        mul_a = MA_W'(ym1_abs);
        mul_b = MB_W'(ym1_abs);
      end
      ST_W3: begin
        mul_a = ry_squared;
        mul_b = t_sq;
      end
      ST_W4: begin
        mul_a = rx_squared;
        mul_b = y_sq;
      end
      ST_W5: begin
        mul_a = rx_squared;
        mul_b = MB_W'(ry_squared);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Incremental update of one walk step.
  logic [TERM_W-1:0] h_inc;
  logic [TERM_W-1:0] v_dec;
  logic [DEC_W-1:0]  h4;
  logic [DEC_W-1:0]  v4;
  logic [DEC_W-1:0]  rx4;
  logic [DEC_W-1:0]  ry4;
  logic [OFF_W-1:0]  offset_x_next;
  logic [OFF_W-1:0]  offset_y_next;
  logic [TERM_W-1:0] horiz_term_next;
  logic [TERM_W-1:0] vert_term_next;
  logic [DEC_W-1:0]  decision_next;
  logic              dec_neg;

  assign h_inc   = horiz_term + (TERM_W'(ry_squared) << 1);
  assign v_dec   = vert_term - (TERM_W'(rx_squared) << 1);
  assign h4      = DEC_W'(h_inc) << 2;
  assign v4      = DEC_W'(v_dec) << 2;
  assign rx4     = DEC_W'(rx_squared) << 2;
  assign ry4     = DEC_W'(ry_squared) << 2;
  assign dec_neg = decision[DEC_W-1];

  always_comb begin
    offset_x_next   = offset_x;
    offset_y_next   = offset_y;
    horiz_term_next = horiz_term;
    vert_term_next  = vert_term;
    decision_next   = decision;
    if (!in_region_two) begin
      // Region one always moves in x, and in y when the midpoint lies outside.
      offset_x_next   = offset_x + 1'b1;
      horiz_term_next = h_inc;
      if (dec_neg) begin
        decision_next = decision + h4 + ry4;
      end else begin
        offset_y_next  = offset_y - 1'b1;
        vert_term_next = v_dec;
        decision_next  = decision + h4 - v4 + ry4;
      end
    end else begin
      // Region two always moves in y, and in x when the midpoint lies inside.
      offset_y_next  = offset_y - 1'b1;
      vert_term_next = v_dec;
      if (!dec_neg && decision != '0) begin
        decision_next = decision + rx4 - v4;
      end else begin
        offset_x_next   = offset_x + 1'b1;
        horiz_term_next = h_inc;
        decision_next   = decision + h4 - v4 + rx4;
      end
    end
  end

  // Mirrored pixel coordinates of the current offset, wrapped to the output width.
  logic [EXT_W-1:0] ox_e;
  logic [EXT_W-1:0] oy_e;
  logic [EXT_W-1:0] dx_e;
  logic [EXT_W-1:0] dy_e;
  logic             at_last;
  logic             out_room;

  assign ox_e     = EXT_W'(origin_x);
  assign oy_e     = EXT_W'(origin_y);
  assign dx_e     = EXT_W'(offset_x);
  assign dy_e     = EXT_W'(offset_y);
  assign at_last  = (offset_y == '0);
  assign out_room = !out_valid || out_ready;

  // Result valid: raised when a point is emitted, dropped once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_room) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_READY;
      busy          <= 1'b0;
      in_region_two <= 1'b0;
    end else begin
      case (state)
        ST_READY: begin
          if (pop_valid) begin
            if (req_kind == ACT_START) begin
              state <= ST_RX;
            end else if (busy) begin
              if (!in_region_two && !(horiz_term < vert_term)) begin
                state <= ST_W1;
              end else begin
                state <= ST_EMIT;
              end
            end
          end
        end
        ST_RX: state <= ST_RY;
        ST_RY: state <= ST_VT;
        ST_VT: state <= ST_SD;
        ST_SD: begin
          busy          <= 1'b1;
          in_region_two <= 1'b0;
          state         <= ST_READY;
        end
        ST_W1: state <= ST_W2;
        ST_W2: state <= ST_W3;
        ST_W3: state <= ST_W4;
        ST_W4: state <= ST_W5;
        ST_W5: state <= ST_W6;
        ST_W6: begin
          in_region_two <= 1'b1;
          state         <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_room) begin
            if (at_last) begin
              busy <= 1'b0;
            end
            state <= ST_READY;
          end
        end
        default: state <= ST_READY;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= DEC_W'(mul_a * mul_b);
    case (state)
      ST_READY: begin
        if (pop_valid && req_kind == ACT_START) begin
          origin_x <= req_cx;
          origin_y <= req_cy;
          rad_x    <= req_rx;
          rad_y    <= req_ry;
        end
      end
      ST_RY: begin
        rx_squared <= SQ_W'(prod);
      end
      ST_VT: begin
        ry_squared <= SQ_W'(prod);
      end
      ST_SD: begin
        // Here the product holds rx^2 * ry.
        offset_x   <= '0;
        offset_y   <= OFF_W'(rad_y);
        horiz_term <= '0;
        vert_term  <= TERM_W'(prod) << 1;
        decision   <= ry4 - (prod << 2) + DEC_W'(rx_squared);
      end
      ST_W2: begin
        t_sq <= PSQ_W'(prod);
      end
      ST_W3: begin
        y_sq <= PSQ_W'(prod);
      end
      ST_W4: begin
        decision <= prod;
      end
      ST_W5: begin
        decision <= decision + (prod << 2);
      end
      ST_W6: begin
        decision <= decision - (prod << 2);
      end
      ST_EMIT: begin
        if (out_room) begin
          left_x   <= OUT_W'(ox_e - dx_e);
          right_x  <= OUT_W'(ox_e + dx_e);
          top_y    <= OUT_W'(oy_e - dy_e);
          bottom_y <= OUT_W'(oy_e + dy_e);
          last     <= at_last;
          if (!at_last) begin
            offset_x   <= offset_x_next;
            offset_y   <= offset_y_next;
            horiz_term <= horiz_term_next;
            vert_term  <= vert_term_next;
            decision   <= decision_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/midpoint_ellipse_rasterizer.sv
// A step request passes through the front input register and the queue; the back sequencer
// dequeues it, then emits its point, and takes no new request before that point is emitted.
// A start request holds the back sequencer through its setup states (RX, RY, VT, SD); the switch into
// region two adds the states W1 to W6 once per ellipse. A step while idle is dequeued and dropped.
// Reset (rst, synchronous, active high) empties the input register and the queue,
// drops any pending point and leaves the block idle with no walk in progress.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        action,
  input  wire logic [COORD_BITS-1:0]       center_x,
  input  wire logic [COORD_BITS-1:0]       center_y,
  input  wire logic [RADIUS_BITS-1:0]      radius_x,
  input  wire logic [RADIUS_BITS-1:0]      radius_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [mer_pkg::OUT_W-1:0] left_x,
  output logic signed [mer_pkg::OUT_W-1:0] right_x,
  output logic signed [mer_pkg::OUT_W-1:0] top_y,
  output logic signed [mer_pkg::OUT_W-1:0] bottom_y,
  output logic                             last
);
  import mer_pkg::*;

  localparam int ENTRY_W = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  // Front: registers and classifies incoming requests.
  mer_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius_x   (radius_x),
    .radius_y   (radius_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue that decouples the front from the back.
  mer_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: setup multiplies and the incremental midpoint walk.
  mer_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_x    (left_x),
    .right_x   (right_x),
    .top_y     (top_y),
    .bottom_y  (bottom_y),
    .last      (last)
  );

endmodule

`default_nettype wire

FILE: rtl/mer_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_checker #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             action,
  input wire logic [COORD_BITS-1:0]            center_x,
  input wire logic [COORD_BITS-1:0]            center_y,
  input wire logic [RADIUS_BITS-1:0]           radius_x,
  input wire logic [RADIUS_BITS-1:0]           radius_y,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [mer_pkg::OUT_W-1:0] left_x,
  input wire logic signed [mer_pkg::OUT_W-1:0] right_x,
  input wire logic signed [mer_pkg::OUT_W-1:0] top_y,
  input wire logic signed [mer_pkg::OUT_W-1:0] bottom_y,
  input wire logic                             last
);
  import mer_pkg::*;

  logic seen_start;
  logic geom_seen;

  // Remembers whether any start request has been accepted since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_start <= 1'b0;
    end else if (in_valid && in_ready && action == ACT_START) begin
      seen_start <= 1'b1;
    end
  end

  // Geometry inputs are watched only so that every port of the top level is observed.
  assign geom_seen = ^{center_x, center_y, radius_x, radius_y} || 1'b1;

  // A stalled point stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("point withdrawn while stalled");

  // A stalled point keeps its coordinates.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(left_x) && $stable(right_x) &&
      $stable(top_y) && $stable(bottom_y) && $stable(last))
    else $error("point changed while stalled");

  // No point is produced before an ellipse has been started.
  a_needs_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seen_start && geom_seen)
    else $error("point produced with no ellipse started");

  // Mirrored coordinates differ by twice the offset, so they share parity.
  a_mirror_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_x[0] == right_x[0]) && (top_y[0] == bottom_y[0]))
    else $error("mirrored coordinates are not symmetric");

  // The final point lies on the center row.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> top_y == bottom_y)
    else $error("final point is off the center row");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
  .COORD_BITS  (COORD_BITS),
  .RADIUS_BITS (RADIUS_BITS)
) u_mer_checker (.*);

`default_nettype wire

FILE: tb/midpoint_ellipse_rasterizer_tb.sv
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;
  import mer_pkg::*;

  localparam int COORD_W  = COORD_BITS_DEF;
  localparam int RADIUS_W = RADIUS_BITS_DEF;
  // The walk arithmetic is kept in a wide modular accumulator; its top bit is the sign.
  localparam int ACC_W    = 64;

  // One emitted point: the four mirrored pixels of the current offset.
  typedef struct {
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] top_y;
    logic signed [OUT_W-1:0] bottom_y;
    logic                    last;
  } pixel_quad_t;

  // Tracks the ellipse walk and holds the points still owed by the block.
  class point_scoreboard;
    bit [ACC_W-1:0] ofs_x, ofs_y, decision, horiz_term, vert_term;
    bit [ACC_W-1:0] rx_sq, ry_sq, org_x, org_y;
    bit             in_region_two;
    bit             walking;
    pixel_quad_t    pending_points[$];
    int unsigned    mismatches;

    // Works out the point, if any, that one accepted request causes.
    function void take_request(logic act, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [RADIUS_W-1:0] rx, logic [RADIUS_W-1:0] ry);
      bit [ACC_W-1:0] tx, ym1;
      pixel_quad_t    pt;
      if (act == ACT_START) begin
        org_x = ACC_W'(cx);
        org_y = ACC_W'(cy);
        rx_sq = ACC_W'(rx) * ACC_W'(rx);
        ry_sq = ACC_W'(ry) * ACC_W'(ry);
        ofs_x = 0;
        ofs_y = ACC_W'(ry);
        horiz_term = 0;
        vert_term = 2 * rx_sq * ACC_W'(ry);
        decision = 4 * ry_sq - 4 * rx_sq * ACC_W'(ry) + rx_sq;
        in_region_two = 1'b0;
        walking = 1'b1;
        return;
      end
      if (!walking) return;

      // The switch into region two is decided before the point goes out.
      if (!in_region_two && !(horiz_term < vert_term)) begin
        tx = 2 * ofs_x + 1;
        ym1 = ofs_y - 1;
        in_region_two = 1'b1;
        decision = ry_sq * tx * tx + 4 * rx_sq * (ym1 * ym1) - 4 * rx_sq * ry_sq;
      end

      pt.left_x   = OUT_W'(org_x - ofs_x);
      pt.right_x  = OUT_W'(org_x + ofs_x);
      pt.top_y    = OUT_W'(org_y - ofs_y);
      pt.bottom_y = OUT_W'(org_y + ofs_y);
      pt.last     = (ofs_y == 0);
      pending_points.push_back(pt);
      if (pt.last) begin
        walking = 1'b0;
        return;
      end

      // Advance one pixel by the incremental update of the current region.
      if (!in_region_two) begin
        ofs_x += 1;
        horiz_term += 2 * ry_sq;
        if (decision[ACC_W-1]) begin
          decision += 4 * horiz_term + 4 * ry_sq;
        end else begin
          ofs_y -= 1;
          vert_term -= 2 * rx_sq;
          decision += 4 * horiz_term - 4 * vert_term + 4 * ry_sq;
        end
      end else begin
        ofs_y -= 1;
        vert_term -= 2 * rx_sq;
        if (!decision[ACC_W-1] && decision != 0) begin
          decision += 4 * rx_sq - 4 * vert_term;
        end else begin
          ofs_x += 1;
          horiz_term += 2 * ry_sq;
          decision += 4 * horiz_term - 4 * vert_term + 4 * rx_sq;
        end
      end
    endfunction

    function void check_field(string name, logic signed [OUT_W-1:0] want,
                              logic signed [OUT_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    // Compares a delivered point with the oldest one owed.
    function void check_point(pixel_quad_t got);
      pixel_quad_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        $error("point at x %0d, y %0d delivered with none owed", got.left_x, got.top_y);
        return;
      end
      want = pending_points.pop_front();
      check_field("left_x", want.left_x, got.left_x);
      check_field("right_x", want.right_x, got.right_x);
      check_field("top_y", want.top_y, got.top_y);
      check_field("bottom_y", want.bottom_y, got.bottom_y);
      check_field("last", OUT_W'(want.last), OUT_W'(got.last));
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     action = ACT_STEP;
  logic [COORD_W-1:0]       center_x = '0;
  logic [COORD_W-1:0]       center_y = '0;
  logic [RADIUS_W-1:0]      radius_x = '0;
  logic [RADIUS_W-1:0]      radius_y = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [OUT_W-1:0]  left_x, right_x, top_y, bottom_y;
  logic                     last;

  point_scoreboard quad_book = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     counted_items = 0;

  midpoint_ellipse_rasterizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .center_x(center_x), .center_y(center_y),
    .radius_x(radius_x), .radius_y(radius_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_x(left_x), .right_x(right_x), .top_y(top_y), .bottom_y(bottom_y),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random back-pressure and a check of every delivered point.
  always @(posedge clk) begin : collect
    pixel_quad_t seen;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen.left_x   = left_x;
        seen.right_x  = right_x;
        seen.top_y    = top_y;
        seen.bottom_y = bottom_y;
        seen.last     = last;
        quad_book.check_point(seen);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drives one request, waits for its acceptance and records it.
  task automatic send_request(logic act, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              logic [RADIUS_W-1:0] rx, logic [RADIUS_W-1:0] ry);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    center_x <= cx;
    center_y <= cy;
    radius_x <= rx;
    radius_y <= ry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Steps while idle are ignored by the block and do not count.
    if (act == ACT_START || quad_book.walking) counted_items++;
    quad_book.take_request(act, cx, cy, rx, ry);
  endtask

  task automatic start_ellipse(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [RADIUS_W-1:0] rx, logic [RADIUS_W-1:0] ry);
    send_request(ACT_START, cx, cy, rx, ry);
  endtask

  // A step carries junk in the unused fields.
  task automatic step_point();
    send_request(ACT_STEP, COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
                 RADIUS_W'($urandom_range(511)), RADIUS_W'($urandom_range(511)));
  endtask

  task automatic finish_walk();
    while (quad_book.walking) step_point();
  endtask

  // Mostly small radii, now and then a mid-size or large one.
  function automatic logic [RADIUS_W-1:0] pick_radius();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 1) return RADIUS_W'($urandom_range(511, 64));
    if (roll < 20) return RADIUS_W'($urandom_range(63));
    return RADIUS_W'($urandom_range(12));
  endfunction

  // Random traffic: complete walks, abandoned walks and raw noise.
  task automatic random_phase(int unsigned upto);
    int unsigned kind;
    while (counted_items < upto) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        start_ellipse(COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
                      pick_radius(), pick_radius());
        finish_walk();
        if ($urandom_range(9) == 0) step_point();
      end else if (kind < 90) begin
        start_ellipse(COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
                      pick_radius(), pick_radius());
        repeat ($urandom_range(6)) step_point();
      end else begin
        send_request(1'($urandom_range(1)), COORD_W'($urandom_range(1023)),
                     COORD_W'($urandom_range(1023)), RADIUS_W'($urandom_range(511)),
                     RADIUS_W'($urandom_range(511)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 77;

    // Directed: idle step, degenerate radii, extremes and restarts mid-walk.
    step_point();
    start_ellipse(0, 0, 0, 0);
    step_point();
    start_ellipse(1023, 1023, 0, 3);
    finish_walk();
    start_ellipse(5, 7, 4, 0);
    step_point();
    start_ellipse(512, 300, 3, 2);
    finish_walk();
    start_ellipse(0, 1023, 511, 511);
    repeat (3) step_point();
    start_ellipse(1023, 0, 511, 1);
    repeat (2) step_point();
    start_ellipse(700, 20, 1, 511);
    repeat (2) step_point();

    random_phase(400);

    send_idle_pct = 77;
    recv_idle_pct = 36;
    random_phase(750);

    // No idling on either side; one full walk at the largest radii first.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    start_ellipse(COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)), 511, 511);
    finish_walk();
    random_phase(1450);

    in_valid <= 1'b0;
    while (quad_book.pending_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (quad_book.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
